// ----- rtl/ens_pkg.sv -----
// Shared types, constants and helpers for the edge non-maximum suppression unit.
// Depends on nothing; imported by ens_window and edge_nonmax_suppression_unit.
package ens_pkg;

    // Field and register widths fixed by the interface
    localparam int MAG_W      = 8;
    localparam int DIR_IN_W   = 8;
    localparam int DIR_W      = 3;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_WID_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_HGT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef logic [DIR_W-1:0] ens_dir_t;

    // Internal direction codes
    localparam ens_dir_t DIR_H    = 3'd0;
    localparam ens_dir_t DIR_D45  = 3'd1;
    localparam ens_dir_t DIR_V    = 3'd2;
    localparam ens_dir_t DIR_D135 = 3'd3;
    localparam ens_dir_t DIR_NONE = 3'd4;

    // Incoming angle codes
    localparam logic [DIR_IN_W-1:0] ANGLE_0   = 8'd0;
    localparam logic [DIR_IN_W-1:0] ANGLE_45  = 8'd45;
    localparam logic [DIR_IN_W-1:0] ANGLE_90  = 8'd90;
    localparam logic [DIR_IN_W-1:0] ANGLE_135 = 8'd135;

    // Line store word: upper magnitude, middle magnitude, middle direction
    localparam int LINE_W = 2 * MAG_W + DIR_W;

    // Control from the pipeline to the window
    typedef struct packed {
        logic shift;     // window takes one column this cycle
        logic delayed;   // result belongs to a real pixel of this frame
        logic interior;  // centre is off the frame border
    } ens_win_ctl_t;

    function automatic ens_dir_t encode_dir(input logic [DIR_IN_W-1:0] angle);
        ens_dir_t code;
        case (angle)
            ANGLE_0:   code = DIR_H;
            ANGLE_45:  code = DIR_D45;
            ANGLE_90:  code = DIR_V;
            ANGLE_135: code = DIR_D135;
            default:   code = DIR_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/ens_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ens_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ens_window.sv -----
// 3x3 magnitude window, centre direction delay and the suppression compare.
// Depends on ens_pkg.
module ens_window
    import ens_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ens_win_ctl_t     ctl,
    input  logic [MAG_W-1:0] up,
    input  logic [MAG_W-1:0] mid,
    input  logic [MAG_W-1:0] mag,
    input  ens_dir_t         dmid,
    output logic [MAG_W-1:0] result
);

    logic [MAG_W-1:0] win_reg  [9];
    logic [MAG_W-1:0] win_next [9];
    ens_dir_t         dly_reg  [2];
    logic [MAG_W-1:0] centre;
    logic [MAG_W-1:0] n1;
    logic [MAG_W-1:0] n2;

    // Window after one column shift: new column is up / mid / incoming
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            dly_reg[0] <= DIR_H;
            dly_reg[1] <= DIR_H;
        end
        else if (ctl.shift)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            dly_reg[0] <= dly_reg[1];
            dly_reg[1] <= dmid;
        end
    end

    // Neighbor pick along the centre's direction
    assign centre = win_next[4];

    always_comb
    begin
        case (dly_reg[1])
            DIR_H:
            begin
                n1 = win_next[3];
                n2 = win_next[5];
            end
            DIR_V:
            begin
                n1 = win_next[1];
                n2 = win_next[7];
            end
            DIR_D45:
            begin
                n1 = win_next[2];
                n2 = win_next[6];
            end
            DIR_D135:
            begin
                n1 = win_next[0];
                n2 = win_next[8];
            end
            default:
            begin
                n1 = '0;
                n2 = '0;
            end
        endcase
    end

    // Keep the centre only as a nonzero interior local maximum
    always_comb
    begin
        if (ctl.delayed && ctl.interior && (centre != '0) && (centre >= n1) && (centre >= n2))
        begin
            result = centre;
        end
        else
        begin
            result = '0;
        end
    end

endmodule

// ----- rtl/edge_nonmax_suppression_unit.sv -----
// Top level of the streaming 3x3 Canny non-maximum suppression unit.
// Depends on ens_pkg, ens_ram and ens_window.
//
// Usage:
//   Pixels arrive in raster order on the input channel (in_valid / in_ready),
//   each a gradient magnitude and an angle code (0, 45, 90, 135; anything else
//   compares against zero neighbors). Every request yields exactly one result
//   request on the output channel (out_valid / out_ready): the suppressed
//   magnitude of the pixel image_width+1 positions earlier, or a zero with
//   is_delayed_pixel low for the leading image_width+1 positions of a frame.
//   Throughput is one pixel per clock while out_ready is high; a result is offered
//   after its line store read (read stage) and window update into the output.
//   The line store is one RAM read and written once per pixel; a pixel that
//   reuses the column just written (image width of one) takes the write data
//   through a bypass register.
//   image_width and image_height are set through cfg_we / cfg_index / cfg_data
//   while the unit is idle; zero acts as one, larger values saturate.
//   Reset clears counters, window and handshake state; the line store is not
//   cleared and needs no clearing pass. When the receiver stalls, the output
//   register holds, one more pixel waits in the read stage, then in_ready drops.
module edge_nonmax_suppression_unit
    import ens_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MAG_W-1:0]      grad_magnitude,
    input  logic [DIR_IN_W-1:0]   grad_direction,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MAG_W-1:0]      suppressed_value,
    output logic                  is_delayed_pixel
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CEXT = (CW + 1 > CFG_WID_W) ? CW + 1 : CFG_WID_W;
    localparam int REXT = (RW + 1 > CFG_HGT_W) ? RW + 1 : CFG_HGT_W;

    // Configuration registers
    logic [CFG_WID_W-1:0] width_reg;
    logic [CFG_HGT_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[CFG_WID_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[CFG_HGT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, saturate at the maxima
    logic [CFG_WID_W-1:0] ew;
    logic [CFG_HGT_W-1:0] eh;

    always_comb
    begin
        if (width_reg == '0)
            ew = CFG_WID_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            ew = CFG_WID_W'(MAX_WIDTH);
        else
            ew = width_reg;
        if (height_reg == '0)
            eh = CFG_HGT_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eh = CFG_HGT_W'(MAX_HEIGHT);
        else
            eh = height_reg;
    end

    // Handshake and pipeline control
    logic p1_valid_reg, p1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_accept;
    logic p1_adv;

    assign p1_adv    = p1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !p1_valid_reg || p1_adv;
    assign in_accept = in_valid && in_ready;

    assign p1_valid_next  = in_accept ? 1'b1 : (p1_adv ? 1'b0 : p1_valid_reg);
    assign out_valid_next = p1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Raster counters
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CEXT-1:0] col_plus;
    logic [REXT-1:0] row_plus;
    logic            col_wrap;
    logic            row_wrap;
    logic            delayed;
    logic            interior;

    assign col_plus = CEXT'(col_reg) + CEXT'(1);
    assign row_plus = REXT'(row_reg) + REXT'(1);
    assign col_wrap = col_plus >= CEXT'(ew);
    assign row_wrap = row_plus >= REXT'(eh);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_plus[RW-1:0];
        end
        else
        begin
            col_next = col_plus[CW-1:0];
        end
    end

    // Frame position flags of this request
    assign delayed  = !((row_reg == '0) || ((row_reg == RW'(1)) && (col_reg == '0)));
    assign interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2))
                    && (col_plus <= CEXT'(ew)) && (row_plus <= REXT'(eh));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read stage: request payload waits here for the line store data
    logic [MAG_W-1:0]  p1_mag_reg;
    ens_dir_t          p1_dir_reg;
    logic [CW-1:0]     p1_col_reg;
    logic              p1_delayed_reg;
    logic              p1_interior_reg;
    logic              fwd_reg, fwd_next;
    logic [LINE_W-1:0] fwd_word_reg;
    logic [LINE_W-1:0] wr_word;
    logic [LINE_W-1:0] rd_word;
    logic [LINE_W-1:0] line_word;
    logic              fwd_hit;

    // Line store write-back: middle moves up, incoming becomes middle
    assign line_word = fwd_reg ? fwd_word_reg : rd_word;
    assign wr_word   = {line_word[LINE_W-MAG_W-1 -: MAG_W], p1_mag_reg, p1_dir_reg};
    assign fwd_hit   = p1_adv && (p1_col_reg == col_reg);
    assign fwd_next  = in_accept ? fwd_hit : (p1_adv ? 1'b0 : fwd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_mag_reg      <= grad_magnitude;
            p1_dir_reg      <= encode_dir(grad_direction);
            p1_col_reg      <= col_reg;
            p1_delayed_reg  <= delayed;
            p1_interior_reg <= interior;
            fwd_word_reg    <= wr_word;
        end
    end

    ens_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (p1_adv),
        .waddr (p1_col_reg),
        .wdata (wr_word),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (rd_word)
    );

    // Window and compare
    ens_win_ctl_t     win_ctl;
    logic [MAG_W-1:0] win_result;

    assign win_ctl.shift    = p1_adv;
    assign win_ctl.delayed  = p1_delayed_reg;
    assign win_ctl.interior = p1_interior_reg;

    ens_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (win_ctl),
        .up     (line_word[LINE_W-1 -: MAG_W]),
        .mid    (line_word[LINE_W-MAG_W-1 -: MAG_W]),
        .mag    (p1_mag_reg),
        .dmid   (line_word[DIR_W-1:0]),
        .result (win_result)
    );

    // Output register
    logic [MAG_W-1:0] out_value_reg;
    logic             out_delayed_reg;

    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            out_value_reg   <= win_result;
            out_delayed_reg <= p1_delayed_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign suppressed_value = out_value_reg;
    assign is_delayed_pixel = out_delayed_reg;

`ifndef SYNTH
    // An accepted request always occupies the read stage next cycle
    a_accept_fills_p1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> p1_valid_reg)
        else $error("accepted request missing from read stage");

    // Bypass is only armed for a request held in the read stage
    a_fwd_with_p1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> p1_valid_reg)
        else $error("line store bypass armed without a request");

    // Leading border results are zero
    a_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_delayed_reg) |-> (out_value_reg == '0))
        else $error("leading border result is nonzero");

    // Output register loads whenever the read stage drains
    a_p1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        p1_adv |=> out_valid_reg)
        else $error("read stage drained without an output");
`endif

endmodule
